// ===== hw/rtl/alfp_pkg.sv =====
`default_nettype none

package alfp_pkg;

  // port field widths
  localparam int OP_W        = 3;
  localparam int ST_W        = 2;
  localparam int SLOT_W      = 4;
  localparam int DATA_W      = 32;
  localparam int IN_TDATA_W  = 40;
  localparam int OUT_TDATA_W = 56;

  // parameter defaults
  localparam int NODES_DEF      = 8;
  localparam int DATA_WIDTH_DEF = 32;

  // operation codes
  localparam logic [OP_W-1:0] OP_CLEAR    = 3'd0;
  localparam logic [OP_W-1:0] OP_INSERT   = 3'd1;
  localparam logic [OP_W-1:0] OP_DELETE   = 3'd2;
  localparam logic [OP_W-1:0] OP_TRAVERSE = 3'd3;
  localparam logic [OP_W-1:0] OP_STATUS   = 3'd4;

  // result status codes
  localparam logic [ST_W-1:0] ST_OK      = 2'd0;
  localparam logic [ST_W-1:0] ST_FULL    = 2'd1;
  localparam logic [ST_W-1:0] ST_EMPTY   = 2'd2;
  localparam logic [ST_W-1:0] ST_BADPRED = 2'd3;

  typedef struct packed {
    logic [ST_W-1:0]   status;
    logic [SLOT_W-1:0] slot;
    logic [DATA_W-1:0] data_out;
    logic [SLOT_W-1:0] next_slot;
    logic [SLOT_W-1:0] head_slot;
    logic [SLOT_W-1:0] free_slot;
    logic              is_empty;
    logic              is_full;
    logic              last;
  } res_t;

endpackage

`default_nettype wire

// ===== hw/rtl/alfp_link_mem.sv =====
`default_nettype none

// Next-pointer memory. Entries never written read as their reset link (i -> i+1, with slot NODES and 0 reading 0).
module alfp_link_mem #(
  parameter int NODES = alfp_pkg::NODES_DEF,
  parameter int PW    = $clog2(alfp_pkg::NODES_DEF + 1)
) (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic [PW-1:0] ra,
  input  wire logic          we,
  input  wire logic [PW-1:0] wa,
  input  wire logic [PW-1:0] wd,
  output logic      [PW-1:0] rd
);

  logic [PW-1:0] mem [0:NODES];
  logic [NODES:0] valid_r;
  logic [PW-1:0]  rd_r;
  logic [PW-1:0]  ra_r;
  logic           rv_r;
  logic           fwd;
  logic [PW-1:0]  dflt;

  assign fwd = we && (wa == ra);

  always_ff @(posedge clk) begin
    if (we) begin
      mem[wa] <= wd;
    end
    rd_r <= fwd ? wd : mem[ra];
    ra_r <= ra;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
      rv_r    <= 1'b0;
    end else begin
      if (we) begin
        valid_r[wa] <= 1'b1;
      end
      rv_r <= valid_r[ra] | fwd;
    end
  end

  assign dflt = ((ra_r != '0) && (int'(ra_r) < NODES)) ? ra_r + PW'(1) : '0;
  assign rd   = rv_r ? rd_r : dflt;

endmodule

`default_nettype wire

// ===== hw/rtl/alfp_data_mem.sv =====
`default_nettype none

// Payload memory. Entries never written read as all ones.
module alfp_data_mem #(
  parameter int NODES = alfp_pkg::NODES_DEF,
  parameter int PW    = $clog2(alfp_pkg::NODES_DEF + 1),
  parameter int DW    = alfp_pkg::DATA_WIDTH_DEF
) (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic [PW-1:0] ra,
  input  wire logic          we,
  input  wire logic [PW-1:0] wa,
  input  wire logic [DW-1:0] wd,
  output logic      [DW-1:0] rd
);

  logic [DW-1:0]  mem [0:NODES];
  logic [NODES:0] valid_r;
  logic [DW-1:0]  rd_r;
  logic           rv_r;
  logic           fwd;

  assign fwd = we && (wa == ra);

  always_ff @(posedge clk) begin
    if (we) begin
      mem[wa] <= wd;
    end
    rd_r <= fwd ? wd : mem[ra];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
      rv_r    <= 1'b0;
    end else begin
      if (we) begin
        valid_r[wa] <= 1'b1;
      end
      rv_r <= valid_r[ra] | fwd;
    end
  end

  assign rd = rv_r ? rd_r : '1;

endmodule

`default_nettype wire

// ===== hw/rtl/alfp_ctrl.sv =====
`default_nettype none

// Request sequencer: reads, modifies and writes back the link and payload memories.
module alfp_ctrl #(
  parameter int NODES = alfp_pkg::NODES_DEF,
  parameter int PW    = $clog2(alfp_pkg::NODES_DEF + 1),
  parameter int DW    = alfp_pkg::DATA_WIDTH_DEF
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          in_valid,
  output logic                               in_ready,
  input  wire logic [alfp_pkg::OP_W-1:0]     in_op,
  input  wire logic [alfp_pkg::SLOT_W-1:0]   in_pred,
  input  wire logic [alfp_pkg::DATA_W-1:0]   in_payload,
  output logic                               res_valid,
  input  wire logic                          res_ready,
  output alfp_pkg::res_t                     res,
  output logic      [PW-1:0]                 lk_ra,
  output logic                               lk_we,
  output logic      [PW-1:0]                 lk_wa,
  output logic      [PW-1:0]                 lk_wd,
  input  wire logic [PW-1:0]                 lk_rd,
  output logic      [PW-1:0]                 dt_ra,
  output logic                               dt_we,
  output logic      [PW-1:0]                 dt_wa,
  output logic      [DW-1:0]                 dt_wd,
  input  wire logic [DW-1:0]                 dt_rd
);

  localparam int SW = alfp_pkg::SLOT_W;
  localparam int XW = alfp_pkg::DATA_W;
  localparam int CW = $clog2(NODES);

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_EXEC  = 4'd1;
  localparam logic [3:0] S_INS1  = 4'd2;
  localparam logic [3:0] S_INS2  = 4'd3;
  localparam logic [3:0] S_INS3  = 4'd4;
  localparam logic [3:0] S_DELH  = 4'd5;
  localparam logic [3:0] S_DELP1 = 4'd6;
  localparam logic [3:0] S_DELP2 = 4'd7;
  localparam logic [3:0] S_DELP3 = 4'd8;
  localparam logic [3:0] S_TRV   = 4'd9;
  localparam logic [3:0] S_EMIT  = 4'd10;

  logic [3:0] state_r, state_nxt;
  logic [alfp_pkg::OP_W-1:0] op_r, op_nxt;
  logic [PW-1:0] pred_r, pred_nxt;
  logic          pred_bad_r, pred_bad_nxt;
  logic [DW-1:0] pay_r, pay_nxt;
  logic [PW-1:0] list_head_r, list_head_nxt;
  logic [PW-1:0] free_head_r, free_head_nxt;
  logic [PW-1:0] t_r, t_nxt;
  logic [PW-1:0] aux_r, aux_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic [alfp_pkg::ST_W-1:0] res_status_r, res_status_nxt;
  logic [PW-1:0] res_slot_r, res_slot_nxt;
  logic [DW-1:0] res_data_r, res_data_nxt;
  logic [PW-1:0] res_next_r, res_next_nxt;
  logic          res_last_r, res_last_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      list_head_r <= '0;
      free_head_r <= PW'(1);
    end else begin
      state_r     <= state_nxt;
      list_head_r <= list_head_nxt;
      free_head_r <= free_head_nxt;
    end
  end

  always_ff @(posedge clk) begin
    op_r         <= op_nxt;
    pred_r       <= pred_nxt;
    pred_bad_r   <= pred_bad_nxt;
    pay_r        <= pay_nxt;
    t_r          <= t_nxt;
    aux_r        <= aux_nxt;
    cnt_r        <= cnt_nxt;
    res_status_r <= res_status_nxt;
    res_slot_r   <= res_slot_nxt;
    res_data_r   <= res_data_nxt;
    res_next_r   <= res_next_nxt;
    res_last_r   <= res_last_nxt;
  end

  always_comb begin
    state_nxt      = state_r;
    op_nxt         = op_r;
    pred_nxt       = pred_r;
    pred_bad_nxt   = pred_bad_r;
    pay_nxt        = pay_r;
    list_head_nxt  = list_head_r;
    free_head_nxt  = free_head_r;
    t_nxt          = t_r;
    aux_nxt        = aux_r;
    cnt_nxt        = cnt_r;
    res_status_nxt = res_status_r;
    res_slot_nxt   = res_slot_r;
    res_data_nxt   = res_data_r;
    res_next_nxt   = res_next_r;
    res_last_nxt   = res_last_r;
    in_ready       = 1'b0;
    lk_ra          = '0;
    lk_we          = 1'b0;
    lk_wa          = t_r;
    lk_wd          = free_head_r;
    dt_ra          = '0;
    dt_we          = 1'b0;
    dt_wa          = t_r;
    dt_wd          = '1;

    unique case (state_r)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          op_nxt       = in_op;
          pred_nxt     = PW'(in_pred);
          pred_bad_nxt = int'(in_pred) > NODES;
          pay_nxt      = DW'(in_payload);
          state_nxt    = S_EXEC;
        end
      end
      S_EXEC: begin
        // single-result default; overridden where the request does real work
        res_status_nxt = alfp_pkg::ST_OK;
        res_slot_nxt   = '0;
        res_data_nxt   = '0;
        res_next_nxt   = '0;
        res_last_nxt   = 1'b1;
        state_nxt      = S_EMIT;
        case (op_r)
          alfp_pkg::OP_CLEAR: begin
            list_head_nxt = '0;
          end
          alfp_pkg::OP_INSERT: begin
            if (free_head_r == '0) begin
              res_status_nxt = alfp_pkg::ST_FULL;
            end else if (pred_bad_r) begin
              res_status_nxt = alfp_pkg::ST_BADPRED;
            end else begin
              lk_ra     = free_head_r;
              t_nxt     = free_head_r;
              state_nxt = S_INS1;
            end
          end
          alfp_pkg::OP_DELETE: begin
            if (list_head_r == '0) begin
              res_status_nxt = alfp_pkg::ST_EMPTY;
            end else if (pred_bad_r) begin
              res_status_nxt = alfp_pkg::ST_BADPRED;
            end else if (pred_r == '0) begin
              lk_ra     = list_head_r;
              dt_ra     = list_head_r;
              t_nxt     = list_head_r;
              state_nxt = S_DELH;
            end else begin
              lk_ra     = pred_r;
              state_nxt = S_DELP1;
            end
          end
          alfp_pkg::OP_TRAVERSE: begin
            if (list_head_r == '0) begin
              res_status_nxt = alfp_pkg::ST_EMPTY;
            end else begin
              lk_ra     = list_head_r;
              dt_ra     = list_head_r;
              t_nxt     = list_head_r;
              cnt_nxt   = '0;
              state_nxt = S_TRV;
            end
          end
          default: begin
          end
        endcase
      end
      S_INS1: begin
        aux_nxt = lk_rd;
        if (pred_r == '0) begin
          lk_we          = 1'b1;
          lk_wd          = list_head_r;
          dt_we          = 1'b1;
          dt_wd          = pay_r;
          list_head_nxt  = t_r;
          free_head_nxt  = lk_rd;
          res_slot_nxt   = t_r;
          res_data_nxt   = pay_r;
          res_next_nxt   = list_head_r;
          state_nxt      = S_EMIT;
        end else begin
          lk_ra     = pred_r;
          state_nxt = S_INS2;
        end
      end
      S_INS2: begin
        lk_we         = 1'b1;
        lk_wd         = lk_rd;
        dt_we         = 1'b1;
        dt_wd         = pay_r;
        free_head_nxt = aux_r;
        res_slot_nxt  = t_r;
        res_data_nxt  = pay_r;
        // predecessor equal to the taken slot ends up pointing at itself
        res_next_nxt  = (pred_r == t_r) ? t_r : lk_rd;
        state_nxt     = S_INS3;
      end
      S_INS3: begin
        lk_we     = 1'b1;
        lk_wa     = pred_r;
        lk_wd     = t_r;
        state_nxt = S_EMIT;
      end
      S_DELH: begin
        list_head_nxt = lk_rd;
        lk_we         = 1'b1;
        dt_we         = 1'b1;
        free_head_nxt = t_r;
        res_slot_nxt  = t_r;
        res_data_nxt  = dt_rd;
        state_nxt     = S_EMIT;
      end
      S_DELP1: begin
        if (lk_rd == '0) begin
          res_status_nxt = alfp_pkg::ST_BADPRED;
          state_nxt      = S_EMIT;
        end else begin
          lk_ra     = lk_rd;
          dt_ra     = lk_rd;
          t_nxt     = lk_rd;
          state_nxt = S_DELP2;
        end
      end
      S_DELP2: begin
        lk_we        = 1'b1;
        lk_wa        = pred_r;
        lk_wd        = lk_rd;
        dt_we        = 1'b1;
        res_slot_nxt = t_r;
        res_data_nxt = dt_rd;
        state_nxt    = S_DELP3;
      end
      S_DELP3: begin
        lk_we         = 1'b1;
        free_head_nxt = t_r;
        state_nxt     = S_EMIT;
      end
      S_TRV: begin
        res_status_nxt = alfp_pkg::ST_OK;
        res_slot_nxt   = t_r;
        res_data_nxt   = dt_rd;
        res_next_nxt   = lk_rd;
        res_last_nxt   = (lk_rd == '0) || (cnt_r == CW'(NODES - 1));
        state_nxt      = S_EMIT;
      end
      S_EMIT: begin
        if (res_ready) begin
          if (res_last_r) begin
            state_nxt = S_IDLE;
          end else begin
            lk_ra     = res_next_r;
            dt_ra     = res_next_r;
            t_nxt     = res_next_r;
            cnt_nxt   = cnt_r + CW'(1);
            state_nxt = S_TRV;
          end
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  assign res_valid     = (state_r == S_EMIT);
  assign res.status    = res_status_r;
  assign res.slot      = SW'(res_slot_r);
  assign res.data_out  = XW'(res_data_r);
  assign res.next_slot = SW'(res_next_r);
  assign res.head_slot = SW'(list_head_r);
  assign res.free_slot = SW'(free_head_r);
  assign res.is_empty  = (list_head_r == '0);
  assign res.is_full   = (free_head_r == '0);
  assign res.last      = res_last_r;

endmodule

`default_nettype wire

// ===== hw/rtl/array_linked_list_free_pool_core.sv =====
// Linked list over a pool of NODES slots (1..NODES, 0 = nil) with a free chain.
// Input stream: one request per beat, op in in_tuser, predecessor and payload in in_tdata.
// Output stream: one result per beat; out_tlast marks the final result of a request.
// Requests are handled one at a time by a sequencer around two single-port-read
// memories (next pointers, payloads) with a registered read. Sequencer states from
// request accept to result in the output register:
//   clear, status, full, empty, predecessor above NODES: EXEC;
//   insert at head: EXEC, INS1; delete at head: EXEC, DELH; delete after a slot
//   with no successor: EXEC, DELP1; insert after predecessor: EXEC, INS1, INS2, INS3;
//   delete after predecessor: EXEC, DELP1, DELP2, DELP3; traverse: EXEC, then TRV per node.
// The sequencer is ready for a new request in the cycle after the last result of the
// previous one moves into the output register. The output register holds its result
// while out_tready is low; the sequencer waits in turn until that register frees up.
// Reset (rst_n low, synchronous) empties the list and sets the free chain to 1..NODES
// at once: per-entry valid bits make unwritten entries read as their reset contents,
// so there is no clearing pass.
`default_nettype none

module array_linked_list_free_pool_core #(
  parameter int NODES      = alfp_pkg::NODES_DEF,
  parameter int DATA_WIDTH = alfp_pkg::DATA_WIDTH_DEF
) (
  input  wire logic                               clk,
  input  wire logic                               rst_n,
  input  wire logic                               in_tvalid,
  output logic                                    in_tready,
  // pred[3:0], payload[35:4], zero pad [39:36]
  input  wire logic [alfp_pkg::IN_TDATA_W-1:0]    in_tdata,
  // op[2:0]
  input  wire logic [alfp_pkg::OP_W-1:0]          in_tuser,
  output logic                                    out_tvalid,
  input  wire logic                               out_tready,
  // slot[3:0], data_out[35:4], next_slot[39:36], head_slot[43:40],
  // free_slot[47:44], is_empty[48], is_full[49], zero pad [55:50]
  output logic      [alfp_pkg::OUT_TDATA_W-1:0]   out_tdata,
  // status[1:0]
  output logic      [alfp_pkg::ST_W-1:0]          out_tuser,
  output logic                                    out_tlast
);

  localparam int PW = $clog2(NODES + 1);
  localparam int SW = alfp_pkg::SLOT_W;
  localparam int XW = alfp_pkg::DATA_W;
  localparam int PAD_W = alfp_pkg::OUT_TDATA_W - (4 * SW + XW + 2);

  logic          res_valid;
  logic          res_ready;
  alfp_pkg::res_t res;
  alfp_pkg::res_t out_res_r;
  logic          out_valid_r;

  logic [PW-1:0]         lk_ra, lk_wa, lk_wd, lk_rd;
  logic                  lk_we;
  logic [PW-1:0]         dt_ra, dt_wa;
  logic [DATA_WIDTH-1:0] dt_wd, dt_rd;
  logic                  dt_we;

  alfp_ctrl #(
    .NODES (NODES),
    .PW    (PW),
    .DW    (DATA_WIDTH)
  ) u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_tvalid),
    .in_ready   (in_tready),
    .in_op      (in_tuser),
    .in_pred    (in_tdata[SW-1:0]),
    .in_payload (in_tdata[SW+XW-1:SW]),
    .res_valid  (res_valid),
    .res_ready  (res_ready),
    .res        (res),
    .lk_ra      (lk_ra),
    .lk_we      (lk_we),
    .lk_wa      (lk_wa),
    .lk_wd      (lk_wd),
    .lk_rd      (lk_rd),
    .dt_ra      (dt_ra),
    .dt_we      (dt_we),
    .dt_wa      (dt_wa),
    .dt_wd      (dt_wd),
    .dt_rd      (dt_rd)
  );

  alfp_link_mem #(
    .NODES (NODES),
    .PW    (PW)
  ) u_link_mem (
    .clk   (clk),
    .rst_n (rst_n),
    .ra    (lk_ra),
    .we    (lk_we),
    .wa    (lk_wa),
    .wd    (lk_wd),
    .rd    (lk_rd)
  );

  alfp_data_mem #(
    .NODES (NODES),
    .PW    (PW),
    .DW    (DATA_WIDTH)
  ) u_data_mem (
    .clk   (clk),
    .rst_n (rst_n),
    .ra    (dt_ra),
    .we    (dt_we),
    .wa    (dt_wa),
    .wd    (dt_wd),
    .rd    (dt_rd)
  );

  // output register
  assign res_ready = !out_valid_r || out_tready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (res_ready) begin
      out_valid_r <= res_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (res_ready && res_valid) begin
      out_res_r <= res;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tuser  = out_res_r.status;
  assign out_tlast  = out_res_r.last;
  assign out_tdata  = {{PAD_W{1'b0}}, out_res_r.is_full, out_res_r.is_empty,
                       out_res_r.free_slot, out_res_r.head_slot, out_res_r.next_slot,
                       out_res_r.data_out, out_res_r.slot};

endmodule

`default_nettype wire

// ===== hw/rtl/alfp_checker.sv =====
`default_nettype none

module alfp_checker (
  input wire logic                             clk,
  input wire logic                             rst_n,
  input wire logic                             in_tready,
  input wire logic                             out_tvalid,
  input wire logic                             out_tready,
  input wire logic [alfp_pkg::OUT_TDATA_W-1:0] out_tdata,
  input wire logic [alfp_pkg::ST_W-1:0]        out_tuser,
  input wire logic                             out_tlast
);

  // stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=>
      out_tvalid && $stable(out_tdata) && $stable(out_tuser) && $stable(out_tlast))
    else $error("result changed while stalled");

  // empty flag agrees with the reported head
  a_empty_head: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tdata[48] |-> out_tdata[43:40] == 4'd0)
    else $error("is_empty set with non-nil head");

  // full flag agrees with the reported free head
  a_full_free: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tdata[49] |-> out_tdata[47:44] == 4'd0)
    else $error("is_full set with non-nil free head");

  // an error result is a single, slotless result
  a_err_single: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser != alfp_pkg::ST_OK |-> out_tlast && out_tdata[3:0] == 4'd0)
    else $error("error result not final or carries a slot");

  // ready for a request right after reset
  a_ready_after_reset: assert property (@(posedge clk)
    !rst_n |=> in_tready && !out_tvalid)
    else $error("not idle after reset");

endmodule

bind array_linked_list_free_pool_core alfp_checker u_alfp_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tuser  (out_tuser),
  .out_tlast  (out_tlast)
);

`default_nettype wire
